// File: design/axis_to_key_tap_converter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the axis to key tap converter
// Shared checks, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AXIS_TO_KEY_TAP_CONVERTER_UNIT_DEFINES_SVH
`define AXIS_TO_KEY_TAP_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication
`define ATKTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ATKTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/atktc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atktc_pkg
// Types, codes and defaults shared by the axis to key tap converter.
// ----------------------------------------------------------------------------
package atktc_pkg;

  // Default sizing
  localparam int CONSUME_SLOTS_DEF = 4;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Key bindings
  localparam logic NEG_KEY_SEL = 1'b0;
  localparam logic POS_KEY_SEL = 1'b1;

  // Input beat kinds
  localparam logic ACTION_EVENT = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_TYPE    = 3'd0,
    CFG_AXIS_CODE     = 3'd1,
    CFG_THRESHOLD     = 3'd2,
    CFG_TAP_TICKS     = 3'd3,
    CFG_MIN_INTERVAL  = 3'd4,
    CFG_CONSUME_LIST  = 3'd5,
    CFG_CONSUME_COUNT = 3'd6
  } cfg_reg_t;

  // Key action codes on the result channel
  typedef enum logic [1:0] {
    KEY_NONE    = 2'd0,
    KEY_PRESS   = 2'd1,
    KEY_RELEASE = 2'd2
  } key_action_t;

  // Register reset values
  localparam logic [7:0]  MATCH_TYPE_RST    = 8'd2;
  localparam logic [15:0] AXIS_CODE_RST     = 16'd0;
  localparam logic [14:0] THRESHOLD_RST     = 15'd100;
  localparam logic [15:0] TAP_TICKS_RST     = 16'd10;
  localparam logic [15:0] MIN_INTERVAL_RST  = 16'd50;
  localparam logic [63:0] CONSUME_LIST_RST  = 64'd0;
  localparam logic [2:0]  CONSUME_COUNT_RST = 3'd1;

  // Classified beat handed from front to back
  typedef struct packed {
    logic               is_tick;
    logic               consumed;
    logic               is_axis;
    logic signed [15:0] value;
  } item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: design/atktc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atktc_queue
// Short FIFO of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module atktc_queue #(
  parameter int DEPTH = atktc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  atktc_pkg::item_t      push_item,
  input  logic                  pop,
  output atktc_pkg::item_t      head_item,
  output atktc_pkg::q_status_t  status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  atktc_pkg::item_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item    = slot_r[rd_ptr_r];
  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);

endmodule

// File: design/atktc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atktc_front
// Accepts input beats and classifies events against type and consume list.
// ----------------------------------------------------------------------------
module atktc_front #(
  parameter int CONSUME_SLOTS = atktc_pkg::CONSUME_SLOTS_DEF
) (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [7:0]            in_event_type,
  input  logic [15:0]           in_event_code,
  input  logic signed [15:0]    in_event_value,
  input  logic [7:0]            match_type,
  input  logic [15:0]           axis_code,
  input  logic [63:0]           consume_list,
  input  logic [2:0]            consume_count,
  input  atktc_pkg::q_status_t  q_status,
  output logic                  push,
  output atktc_pkg::item_t      push_item
);

  logic listed;

  // Code lookup over the enabled consume slots
  always_comb begin
    listed = 1'b0;
    for (int i = 0; i < CONSUME_SLOTS; i++) begin
      if ((3'(i) < consume_count) && (consume_list[16*i +: 16] == in_event_code)) begin
        listed = 1'b1;
      end
    end
  end

  // Classification of the beat
  always_comb begin
    push_item.is_tick  = (in_action == atktc_pkg::ACTION_TICK);
    push_item.consumed = (in_action == atktc_pkg::ACTION_EVENT) &&
                         (in_event_type == match_type) && listed;
    push_item.is_axis  = (in_event_code == axis_code);
    push_item.value    = in_event_value;
  end

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

endmodule

// File: design/atktc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atktc_back
// Runs the tap state: remainder clamp, press, release timing, result register.
// ----------------------------------------------------------------------------
module atktc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [14:0]           threshold,
  input  logic [15:0]           tap_ticks,
  input  logic [15:0]           min_interval_ticks,
  input  atktc_pkg::item_t      head_item,
  input  atktc_pkg::q_status_t  q_status,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_verdict,
  output logic signed [15:0]    out_value_out,
  output logic [1:0]            out_key_action,
  output logic                  out_key_select,
  output logic                  out_busy_flag
);

  // Tap state
  logic signed [15:0] remainder_r, remainder_nxt;
  logic               tap_busy_r, tap_busy_nxt;
  logic [15:0]        tick_count_r, tick_count_nxt;
  logic               held_key_r, held_key_nxt;
  logic               key_down_r, key_down_nxt;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic                   verdict_r, verdict_nxt;
  logic signed [15:0]     value_r, value_nxt;
  atktc_pkg::key_action_t action_r, action_nxt;
  logic                   select_r, select_nxt;
  logic                   busy_flag_r;

  // Datapath terms
  logic signed [16:0] sum, thr_pos, thr_neg, clamped;
  logic               hit_neg, hit_pos;
  logic [15:0]        tick_inc, end_ticks;
  logic               release_now, down_after;

  // Pop when the result register is free or being drained this cycle
  assign pop = !q_status.empty && (!out_valid_r || !out_stall);

  // Clamped accumulate
  assign thr_pos = signed'({2'b00, threshold});
  assign thr_neg = -thr_pos;
  assign sum     = {remainder_r[15], remainder_r} + {head_item.value[15], head_item.value};
  always_comb begin
    if (sum < thr_neg) begin
      clamped = thr_neg;
    end else if (sum > thr_pos) begin
      clamped = thr_pos;
    end else begin
      clamped = sum;
    end
  end
  assign hit_neg = (clamped <= thr_neg);
  assign hit_pos = (clamped >= thr_pos);

  // Tick timing, counter saturates
  assign tick_inc    = (tick_count_r == 16'hFFFF) ? tick_count_r : tick_count_r + 16'd1;
  assign end_ticks   = (tap_ticks > min_interval_ticks) ? tap_ticks : min_interval_ticks;
  assign release_now = key_down_r && (tick_inc >= tap_ticks);
  assign down_after  = key_down_r && !release_now;

  // Per-beat state update and result
  always_comb begin
    remainder_nxt  = remainder_r;
    tap_busy_nxt   = tap_busy_r;
    tick_count_nxt = tick_count_r;
    held_key_nxt   = held_key_r;
    key_down_nxt   = key_down_r;
    verdict_nxt    = 1'b0;
    value_nxt      = '0;
    action_nxt     = atktc_pkg::KEY_NONE;
    select_nxt     = atktc_pkg::NEG_KEY_SEL;
    if (head_item.is_tick) begin
      if (tap_busy_r) begin
        tick_count_nxt = tick_inc;
        key_down_nxt   = down_after;
        if (release_now) begin
          action_nxt = atktc_pkg::KEY_RELEASE;
          select_nxt = held_key_r;
        end
        if (!down_after && (tick_inc >= end_ticks)) begin
          tap_busy_nxt = 1'b0;
        end
      end
    end else if (!head_item.consumed) begin
      value_nxt = head_item.value;
    end else begin
      verdict_nxt = 1'b1;
      if (head_item.is_axis) begin
        remainder_nxt = clamped[15:0];
        if (hit_neg || hit_pos) begin
          remainder_nxt = '0;
          if (!tap_busy_r) begin
            tap_busy_nxt   = 1'b1;
            key_down_nxt   = 1'b1;
            tick_count_nxt = '0;
            held_key_nxt   = hit_neg ? atktc_pkg::NEG_KEY_SEL
                                     : atktc_pkg::POS_KEY_SEL;
            action_nxt     = atktc_pkg::KEY_PRESS;
            select_nxt     = held_key_nxt;
          end
        end
      end
    end
  end

  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remainder_r  <= '0;
      tap_busy_r   <= 1'b0;
      tick_count_r <= '0;
      held_key_r   <= atktc_pkg::NEG_KEY_SEL;
      key_down_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        remainder_r  <= remainder_nxt;
        tap_busy_r   <= tap_busy_nxt;
        tick_count_r <= tick_count_nxt;
        held_key_r   <= held_key_nxt;
        key_down_r   <= key_down_nxt;
      end
    end
  end

  // Result payload, loaded on pop
  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_r   <= verdict_nxt;
      value_r     <= value_nxt;
      action_r    <= action_nxt;
      select_r    <= select_nxt;
      busy_flag_r <= tap_busy_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = verdict_r;
  assign out_value_out  = value_r;
  assign out_key_action = action_r;
  assign out_key_select = select_r;
  assign out_busy_flag  = busy_flag_r;

endmodule

// File: design/axis_to_key_tap_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_to_key_tap_converter_unit
// Turns relative axis motion beats into key press and release taps.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | action, event_type/code/value
//  out_    | output    | out_valid / out_stall| verdict, value_out, key_*, busy
//  cfg_    | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
//  One beat per cycle sustained while out_stall is low; a beat is held in the queue
//  and then in the result register before its result shows on the out_ channel.
//  The back-end tap update (clamped add plus tick compare) sets the cycle.
//  Reset is synchronous: registers return to defaults, tap state clears.
//  out_stall holds the result register; the queue absorbs QUEUE_DEPTH beats
//  before in_stall rises.
// ----------------------------------------------------------------------------
`include "axis_to_key_tap_converter_unit_defines.svh"

module axis_to_key_tap_converter_unit #(
  parameter int CONSUME_SLOTS = atktc_pkg::CONSUME_SLOTS_DEF,
  parameter int QUEUE_DEPTH   = atktc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [7:0]                        in_event_type,
  input  logic [15:0]                       in_event_code,
  input  logic signed [15:0]                in_event_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_verdict,
  output logic signed [15:0]                out_value_out,
  output logic [1:0]                        out_key_action,
  output logic                              out_key_select,
  output logic                              out_busy_flag,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [atktc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [atktc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers
  logic [7:0]  match_type_r;
  logic [15:0] axis_code_r;
  logic [14:0] threshold_r;
  logic [15:0] tap_ticks_r;
  logic [15:0] min_interval_r;
  logic [63:0] consume_list_r;
  logic [2:0]  consume_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_type_r    <= atktc_pkg::MATCH_TYPE_RST;
      axis_code_r     <= atktc_pkg::AXIS_CODE_RST;
      threshold_r     <= atktc_pkg::THRESHOLD_RST;
      tap_ticks_r     <= atktc_pkg::TAP_TICKS_RST;
      min_interval_r  <= atktc_pkg::MIN_INTERVAL_RST;
      consume_list_r  <= atktc_pkg::CONSUME_LIST_RST;
      consume_count_r <= atktc_pkg::CONSUME_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        atktc_pkg::CFG_MATCH_TYPE:    match_type_r    <= cfg_wdata[7:0];
        atktc_pkg::CFG_AXIS_CODE:     axis_code_r     <= cfg_wdata[15:0];
        atktc_pkg::CFG_THRESHOLD:     threshold_r     <= cfg_wdata[14:0];
        atktc_pkg::CFG_TAP_TICKS:     tap_ticks_r     <= cfg_wdata[15:0];
        atktc_pkg::CFG_MIN_INTERVAL:  min_interval_r  <= cfg_wdata[15:0];
        atktc_pkg::CFG_CONSUME_LIST:  consume_list_r  <= cfg_wdata[63:0];
        atktc_pkg::CFG_CONSUME_COUNT: consume_count_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Front, queue, back
  atktc_pkg::item_t     push_item;
  atktc_pkg::item_t     head_item;
  atktc_pkg::q_status_t q_status;
  logic                 push;
  logic                 pop;

  atktc_front #(
    .CONSUME_SLOTS (CONSUME_SLOTS)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_event_type  (in_event_type),
    .in_event_code  (in_event_code),
    .in_event_value (in_event_value),
    .match_type     (match_type_r),
    .axis_code      (axis_code_r),
    .consume_list   (consume_list_r),
    .consume_count  (consume_count_r),
    .q_status       (q_status),
    .push           (push),
    .push_item      (push_item)
  );

  atktc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  atktc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .threshold          (threshold_r),
    .tap_ticks          (tap_ticks_r),
    .min_interval_ticks (min_interval_r),
    .head_item          (head_item),
    .q_status           (q_status),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_verdict        (out_verdict),
    .out_value_out      (out_value_out),
    .out_key_action     (out_key_action),
    .out_key_select     (out_key_select),
    .out_busy_flag      (out_busy_flag)
  );

  // Checks
  `ATKTC_ASSERT_NOW(a_press_busy, out_valid && (out_key_action == atktc_pkg::KEY_PRESS), out_busy_flag, "press without busy")
  `ATKTC_ASSERT_NOW(a_consumed_zero, out_valid && out_verdict, out_value_out == 16'sd0, "consumed beat with nonzero value")
  `ATKTC_ASSERT_NOW(a_release_pass, out_valid && (out_key_action == atktc_pkg::KEY_RELEASE), !out_verdict && (out_value_out == 16'sd0), "release on a non-tick result")
  `ATKTC_ASSERT_NEXT(a_pop_loads, pop, out_valid, "popped beat not in result register")

endmodule
